// File: rtl/hgk_pkg.sv
// Shared constants, types, glyph tables and helpers for the Hellschreiber glyph keyer.
package hgk_pkg;

    localparam int COLUMNS_PER_CHAR  = 7;
    localparam int PIXELS_PER_COLUMN = 7;
    localparam int GLYPH_BYTES       = 5;
    localparam int LETTER_COUNT      = 26;
    localparam int SYMBOL_COUNT      = 14;

    localparam int COL_W   = $clog2(COLUMNS_PER_CHAR);
    localparam int PIX_W   = (PIXELS_PER_COLUMN > 1) ? $clog2(PIXELS_PER_COLUMN) : 1;
    localparam int CHAR_W  = 8;
    localparam int TONE_W  = 12;
    localparam int IDX_W   = $clog2(LETTER_COUNT);
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;
    localparam int REG_BIT = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TONE_W-1:0] TONE_RESET     = 12'd2100;
    localparam logic              REG_TONE_LEVEL = 1'b0;

    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [CHAR_W-1:0] CHAR_COMMA   = 8'h2c;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;

    localparam logic [7:0] BLANK_BYTE = 8'h00;

    typedef enum logic [1:0] {
        GLYPH_BLANK,
        GLYPH_LETTER,
        GLYPH_SYMBOL
    } glyph_kind_t;

    typedef struct packed {
        glyph_kind_t      kind;
        logic [IDX_W-1:0] index;
    } glyph_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    localparam logic [7:0] LETTER_ROM [0:129] = '{
        8'h78,8'h2c,8'h24,8'h2c,8'h78,8'h44,8'h7c,8'h54,8'h54,8'h28,8'h38,8'h6c,8'h44,
        8'h44,8'h28,8'h44,8'h7c,8'h44,8'h44,8'h38,8'h7c,8'h54,8'h54,8'h44,8'h44,8'h7c,
        8'h14,8'h14,8'h04,8'h04,8'h38,8'h6c,8'h44,8'h54,8'h34,8'h7c,8'h10,8'h10,8'h10,
        8'h7c,8'h00,8'h44,8'h7c,8'h44,8'h00,8'h60,8'h40,8'h40,8'h40,8'h7c,8'h7c,8'h10,
        8'h38,8'h28,8'h44,8'h7c,8'h40,8'h40,8'h40,8'h40,8'h7c,8'h08,8'h10,8'h08,8'h7c,
        8'h7c,8'h04,8'h08,8'h10,8'h7c,8'h38,8'h44,8'h44,8'h44,8'h38,8'h44,8'h7c,8'h54,
        8'h14,8'h1c,8'h38,8'h44,8'h64,8'hc4,8'hb8,8'h7c,8'h14,8'h14,8'h34,8'h58,8'h58,
        8'h54,8'h54,8'h54,8'h24,8'h04,8'h04,8'h7c,8'h04,8'h04,8'h7c,8'h40,8'h40,8'h40,
        8'h7c,8'h7c,8'h20,8'h10,8'h08,8'h04,8'h7c,8'h60,8'h7c,8'h40,8'h7c,8'h44,8'h28,
        8'h10,8'h28,8'h44,8'h04,8'h08,8'h70,8'h08,8'h04,8'h44,8'h64,8'h54,8'h4c,8'h64
    };

    localparam logic [7:0] SYMBOL_ROM [0:69] = '{
        8'h80,8'ha0,8'h60,8'h00,8'h00,8'h00,8'h10,8'h10,8'h10,8'h00,8'h40,8'h40,8'h00,
        8'h00,8'h00,8'h40,8'h20,8'h10,8'h08,8'h04,8'h38,8'h64,8'h54,8'h4c,8'h38,8'h04,
        8'h04,8'h7c,8'h00,8'h00,8'h48,8'h64,8'h54,8'h4c,8'h40,8'h44,8'h44,8'h54,8'h54,
        8'h3c,8'h1c,8'h10,8'h10,8'h7c,8'h10,8'h40,8'h5c,8'h54,8'h54,8'h34,8'h3c,8'h52,
        8'h4a,8'h48,8'h30,8'h44,8'h24,8'h14,8'h0c,8'h04,8'h6c,8'h5a,8'h54,8'h5a,8'h6c,
        8'h08,8'h4a,8'h4a,8'h2a,8'h38
    };

    // Map a character code onto a glyph class and its row in the table.
    function automatic glyph_t classify(input logic [CHAR_W-1:0] ch);
        glyph_t g;
        g.kind  = GLYPH_BLANK;
        g.index = '0;
        if (ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            g.kind  = GLYPH_LETTER;
            g.index = IDX_W'(ch - CHAR_LOWER_A);
        end else if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            g.kind  = GLYPH_LETTER;
            g.index = IDX_W'(ch - CHAR_UPPER_A);
        end else if (ch inside {[CHAR_COMMA:CHAR_NINE]}) begin
            g.kind  = GLYPH_SYMBOL;
            g.index = IDX_W'(ch - CHAR_COMMA);
        end
        return g;
    endfunction

    // Column byte of a glyph; only columns 1..GLYPH_BYTES carry ink.
    function automatic logic [7:0] column_byte(input glyph_t g, input logic [COL_W-1:0] col);
        logic [7:0] addr;
        logic [7:0] data;
        addr = 8'(g.index) * 8'(GLYPH_BYTES) + 8'(col) - 8'd1;
        data = BLANK_BYTE;
        if (col != '0 && col <= COL_W'(GLYPH_BYTES)) begin
            case (g.kind)
                GLYPH_LETTER: data = LETTER_ROM[addr];
                GLYPH_SYMBOL: data = SYMBOL_ROM[addr[6:0]];
                default:      data = BLANK_BYTE;
            endcase
        end
        return data;
    endfunction

endpackage

// File: rtl/hgk_front.sv
// Front end: accepts characters and classifies them into glyph entries.
module hgk_front
    import hgk_pkg::*;
(
    input  logic [CHAR_W-1:0] character,
    input  logic              char_valid,
    output logic              char_stall,
    input  queue_status_t     qstat,
    output logic              push,
    output glyph_t            push_data
);

    assign char_stall = qstat.full;
    assign push       = char_valid && !qstat.full;
    assign push_data  = classify(character);

endmodule

// File: rtl/hgk_queue.sv
// Short glyph queue between the front end and the pixel sequencer.
module hgk_queue
    import hgk_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  glyph_t        push_data,
    input  logic          pop,
    output glyph_t        pop_data,
    output queue_status_t qstat
);

    glyph_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data    = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

endmodule

// File: rtl/hgk_back.sv
// Back end: walks each glyph column by column, one pixel word per cycle unless stalled.
module hgk_back
    import hgk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  queue_status_t     qstat,
    output logic              pop,
    input  glyph_t            pop_data,
    input  logic [TONE_W-1:0] tone_level,
    output logic              pix_valid,
    input  logic              pix_stall,
    output logic              key_on,
    output logic [TONE_W-1:0] dac_value,
    output logic              last_pixel
);

    logic              busy_reg;
    logic              busy_next;
    glyph_t            glyph_reg;
    glyph_t            glyph_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [PIX_W-1:0]  pix_reg;
    logic [PIX_W-1:0]  pix_next;
    logic              out_valid_reg;
    logic              key_reg;
    logic [TONE_W-1:0] dac_reg;
    logic              last_reg;

    logic              advance;
    logic              col_end;
    logic              last_pos;
    logic [7:0]        cur_byte;
    logic              cur_bit;

    assign advance  = !out_valid_reg || !pix_stall;
    assign col_end  = (pix_reg == PIX_W'(PIXELS_PER_COLUMN - 1));
    assign last_pos = busy_reg && col_end && (col_reg == COL_W'(COLUMNS_PER_CHAR - 1));
    assign cur_byte = column_byte(glyph_reg, col_reg);
    assign cur_bit  = cur_byte[3'(3'd7 - 3'(pix_reg))];

    // Take the next glyph when idle or as the last pixel of this one leaves.
    assign pop = !qstat.empty && (!busy_reg || (advance && last_pos));

    always_comb
    begin
        busy_next  = busy_reg;
        glyph_next = glyph_reg;
        col_next   = col_reg;
        pix_next   = pix_reg;
        if (busy_reg && advance)
        begin
            if (col_end)
            begin
                pix_next = '0;
                col_next = col_reg + COL_W'(1);
            end
            else
            begin
                pix_next = pix_reg + PIX_W'(1);
            end
            if (last_pos)
            begin
                busy_next = 1'b0;
            end
        end
        if (pop)
        begin
            busy_next  = 1'b1;
            glyph_next = pop_data;
            col_next   = '0;
            pix_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            col_reg       <= '0;
            pix_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
            pix_reg  <= pix_next;
            if (advance)
            begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_reg <= glyph_next;
        if (advance)
        begin
            key_reg  <= cur_bit;
            dac_reg  <= cur_bit ? tone_level : '0;
            last_reg <= last_pos;
        end
    end

    assign pix_valid  = out_valid_reg;
    assign key_on     = key_reg;
    assign dac_value  = dac_reg;
    assign last_pixel = last_reg;

endmodule

// File: rtl/hellschreiber_glyph_keyer.sv
// Hellschreiber glyph keyer top level: register port, front end, queue and pixel sequencer.
//
// Each accepted character produces COLUMNS_PER_CHAR * PIXELS_PER_COLUMN pixel words
// (49 at 7x7), column by column, top pixel first; columns 1..5 come from the glyph
// tables, all other columns and unknown characters are blank, and last_pixel marks the
// final word. The pixel sequencer emits one word per cycle while pix_stall is low, so
// characters follow each other without gaps; a two-entry queue lets the next characters
// be taken while one is still being sent, and the first word of a character that enters
// an idle block is registered in the queue, the sequencer and the output register.
// tone_level (byte address 0, reset 2100) sets dac_value on keyed pixels.
module hellschreiber_glyph_keyer
    import hgk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic [CHAR_W-1:0] character,
    input  logic              char_valid,
    output logic              char_stall,
    output logic              key_on,
    output logic [TONE_W-1:0] dac_value,
    output logic              last_pixel,
    output logic              pix_valid,
    input  logic              pix_stall
);

    logic [TONE_W-1:0] tone_reg;
    logic              tone_sel;
    logic              push;
    logic              pop;
    glyph_t            push_data;
    glyph_t            pop_data;
    queue_status_t     qstat;

    assign pready   = 1'b1;
    assign tone_sel = (paddr[REG_BIT] == REG_TONE_LEVEL);
    assign prdata   = tone_sel ? DATA_W'(tone_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_reg <= TONE_RESET;
        end
        else if (psel && penable && pwrite && tone_sel)
        begin
            tone_reg <= pwdata[TONE_W-1:0];
        end
    end

    hgk_front u_front (
        .character  (character),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .qstat      (qstat),
        .push       (push),
        .push_data  (push_data)
    );

    hgk_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    hgk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .pop        (pop),
        .pop_data   (pop_data),
        .tone_level (tone_reg),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .key_on     (key_on),
        .dac_value  (dac_value),
        .last_pixel (last_pixel)
    );

endmodule

// File: rtl/hgk_checker.sv
// Port-level checks for the Hellschreiber glyph keyer, bound to the top level.
module hgk_checker
    import hgk_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              pix_valid,
    input logic              pix_stall,
    input logic              key_on,
    input logic [TONE_W-1:0] dac_value,
    input logic              last_pixel
);

    // A stalled pixel word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(key_on) && $stable(dac_value)
            && $stable(last_pixel))
        else $error("stalled pixel word changed");

    // An unkeyed pixel drives the DAC to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !key_on |-> dac_value == '0)
        else $error("dac_value nonzero with key off");

    // A glyph is never a single pixel, so two last flags never come back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall && last_pixel |=> !(pix_valid && last_pixel))
        else $error("last_pixel on consecutive words");

endmodule

bind hellschreiber_glyph_keyer hgk_checker u_hgk_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .key_on     (key_on),
    .dac_value  (dac_value),
    .last_pixel (last_pixel)
);

// File: dv/glyph_pattern_checker.sv
// Pixel pattern predictor and tone_level readback checker for the Hellschreiber glyph keyer.
`timescale 1ns / 1ps

module glyph_pattern_checker
    import hgk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    input  logic [CHAR_W-1:0] character,
    input  logic              char_valid,
    input  logic              char_stall,
    input  logic              key_on,
    input  logic [TONE_W-1:0] dac_value,
    input  logic              last_pixel,
    input  logic              pix_valid,
    input  logic              pix_stall,
    output int                mismatches,
    output int                outstanding
);

    localparam int                GLYPH_WIDTH  = 5;
    localparam logic [TONE_W-1:0] TONE_DEFAULT = 12'd2100;

    localparam logic [7:0] letter_cols [0:129] = '{
        8'h78,8'h2c,8'h24,8'h2c,8'h78, 8'h44,8'h7c,8'h54,8'h54,8'h28,
        8'h38,8'h6c,8'h44,8'h44,8'h28, 8'h44,8'h7c,8'h44,8'h44,8'h38,
        8'h7c,8'h54,8'h54,8'h44,8'h44, 8'h7c,8'h14,8'h14,8'h04,8'h04,
        8'h38,8'h6c,8'h44,8'h54,8'h34, 8'h7c,8'h10,8'h10,8'h10,8'h7c,
        8'h00,8'h44,8'h7c,8'h44,8'h00, 8'h60,8'h40,8'h40,8'h40,8'h7c,
        8'h7c,8'h10,8'h38,8'h28,8'h44, 8'h7c,8'h40,8'h40,8'h40,8'h40,
        8'h7c,8'h08,8'h10,8'h08,8'h7c, 8'h7c,8'h04,8'h08,8'h10,8'h7c,
        8'h38,8'h44,8'h44,8'h44,8'h38, 8'h44,8'h7c,8'h54,8'h14,8'h1c,
        8'h38,8'h44,8'h64,8'hc4,8'hb8, 8'h7c,8'h14,8'h14,8'h34,8'h58,
        8'h58,8'h54,8'h54,8'h54,8'h24, 8'h04,8'h04,8'h7c,8'h04,8'h04,
        8'h7c,8'h40,8'h40,8'h40,8'h7c, 8'h7c,8'h20,8'h10,8'h08,8'h04,
        8'h7c,8'h60,8'h7c,8'h40,8'h7c, 8'h44,8'h28,8'h10,8'h28,8'h44,
        8'h04,8'h08,8'h70,8'h08,8'h04, 8'h44,8'h64,8'h54,8'h4c,8'h64
    };

    localparam logic [7:0] symbol_cols [0:69] = '{
        8'h80,8'ha0,8'h60,8'h00,8'h00, 8'h00,8'h10,8'h10,8'h10,8'h00,
        8'h40,8'h40,8'h00,8'h00,8'h00, 8'h40,8'h20,8'h10,8'h08,8'h04,
        8'h38,8'h64,8'h54,8'h4c,8'h38, 8'h04,8'h04,8'h7c,8'h00,8'h00,
        8'h48,8'h64,8'h54,8'h4c,8'h40, 8'h44,8'h44,8'h54,8'h54,8'h3c,
        8'h1c,8'h10,8'h10,8'h7c,8'h10, 8'h40,8'h5c,8'h54,8'h54,8'h34,
        8'h3c,8'h52,8'h4a,8'h48,8'h30, 8'h44,8'h24,8'h14,8'h0c,8'h04,
        8'h6c,8'h5a,8'h54,8'h5a,8'h6c, 8'h08,8'h4a,8'h4a,8'h2a,8'h38
    };

    typedef struct packed {
        logic              key;
        logic [TONE_W-1:0] dac;
        logic              last;
    } pixel_word_t;

    pixel_word_t       pending_pixels [$];
    logic [TONE_W-1:0] tone;

    // Ink byte of one column; blank outside the glyph columns and for unknown codes.
    function automatic logic [7:0] column_of(input logic [CHAR_W-1:0] ch, input int col);
        int slot;
        slot = col - 1;
        if (col < 1 || col > GLYPH_WIDTH)
            return 8'h00;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
            return letter_cols[(int'(ch) - int'(CHAR_LOWER_A)) * GLYPH_WIDTH + slot];
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
            return letter_cols[(int'(ch) - int'(CHAR_UPPER_A)) * GLYPH_WIDTH + slot];
        if (ch >= CHAR_COMMA && ch <= CHAR_NINE)
            return symbol_cols[(int'(ch) - int'(CHAR_COMMA)) * GLYPH_WIDTH + slot];
        return 8'h00;
    endfunction

    // Queue every pixel of one character, column by column, top pixel first.
    task automatic expand_glyph(input logic [CHAR_W-1:0] ch);
        int          total;
        int          n;
        logic [7:0]  bits;
        pixel_word_t w;
        total = COLUMNS_PER_CHAR * PIXELS_PER_COLUMN;
        n = 0;
        for (int col = 0; col < COLUMNS_PER_CHAR; col++) begin
            bits = column_of(ch, col);
            for (int pix = 0; pix < PIXELS_PER_COLUMN && pix < 8; pix++) begin
                w.key  = bits[7 - pix];
                w.dac  = w.key ? tone : '0;
                w.last = (n + 1 == total);
                pending_pixels.push_back(w);
                n++;
            end
        end
    endtask

    task automatic compare_pixel();
        pixel_word_t want;
        if (pending_pixels.size() == 0) begin
            $error("pixel word with nothing outstanding");
            mismatches++;
            return;
        end
        want = pending_pixels.pop_front();
        if (key_on !== want.key) begin
            $error("key_on: expected %0d, got %0d", want.key, key_on);
            mismatches++;
        end
        if (dac_value !== want.dac) begin
            $error("dac_value: expected %0d, got %0d", want.dac, dac_value);
            mismatches++;
        end
        if (last_pixel !== want.last) begin
            $error("last_pixel: expected %0d, got %0d", want.last, last_pixel);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tone = TONE_DEFAULT;
            pending_pixels.delete();
            mismatches = 0;
            outstanding = 0;
        end else begin
            if (psel && penable && pready && paddr[ADDR_W-1:REG_BIT] == REG_TONE_LEVEL) begin
                if (pwrite) begin
                    tone = pwdata[TONE_W-1:0];
                end else if (prdata !== DATA_W'(tone)) begin
                    $error("tone_level: expected %0d, got %0d", tone, prdata);
                    mismatches++;
                end
            end
            // Retire before queueing so a word never matches a newer character.
            if (pix_valid && !pix_stall)
                compare_pixel();
            if (char_valid && !char_stall)
                expand_glyph(character);
            outstanding = pending_pixels.size();
        end
    end

endmodule

// File: dv/hellschreiber_glyph_keyer_tb.sv
// Stimulus, clocking and verdict for the Hellschreiber glyph keyer testbench.
`timescale 1ns / 1ps

module hellschreiber_glyph_keyer_tb;
    import hgk_pkg::*;

    localparam int                WATCHDOG_CYCLES = 600000;
    localparam int                SETTLE_CYCLES   = 6;
    localparam int                REG_SPARE       = 1;
    localparam logic [ADDR_W-1:0] ADDR_TONE       = ADDR_W'(REG_TONE_LEVEL) << REG_BIT;
    localparam logic [ADDR_W-1:0] ADDR_SPARE      = ADDR_W'(REG_SPARE) << REG_BIT;

    // Ends of each glyph range, their outside neighbors, the byte extremes, 8'h7f and 8'h80,
    // glyphs that use the top pixel bit, and the glyphs '0', 'M' and '.'.
    localparam logic [CHAR_W-1:0] corner_chars [0:20] = '{
        8'h41, 8'h5a, 8'h61, 8'h7a, 8'h2c, 8'h39, 8'h51, 8'h71, 8'h2b, 8'h3a, 8'h40,
        8'h5b, 8'h60, 8'h7b, 8'h00, 8'hff, 8'h80, 8'h7f, 8'h30, 8'h4d, 8'h2e
    };

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic [CHAR_W-1:0] character;
    logic              char_valid;
    logic              char_stall;
    logic              key_on;
    logic [TONE_W-1:0] dac_value;
    logic              last_pixel;
    logic              pix_valid;
    logic              pix_stall;

    int mismatches;
    int outstanding;
    bit gapless;

    hellschreiber_glyph_keyer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .character  (character),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .key_on     (key_on),
        .dac_value  (dac_value),
        .last_pixel (last_pixel),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall)
    );

    glyph_pattern_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .character   (character),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .key_on      (key_on),
        .dac_value   (dac_value),
        .last_pixel  (last_pixel),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (WATCHDOG_CYCLES) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // Pixel receiver: after each word, stall for a drawn number of cycles;
    // every third stretch of words goes through without stalls.
    initial
    begin
        int words;
        int hold;
        words = 0;
        pix_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pix_valid && !pix_stall) begin
                words++;
                hold = ((words % 300) >= 200) ? 0 : $urandom_range(0, 9);
                @(negedge clk);
                if (hold > 0) begin
                    pix_stall <= 1'b1;
                    repeat (hold) @(negedge clk);
                    pix_stall <= 1'b0;
                end
            end
        end
    end

    // Mostly glyph characters, the rest any byte.
    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return CHAR_W'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
            3, 4, 5: return CHAR_W'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
            6, 7:    return CHAR_W'($urandom_range(CHAR_COMMA, CHAR_NINE));
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Entered and left at a falling edge.
    task automatic send_char(input logic [CHAR_W-1:0] ch);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            char_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        character  <= ch;
        char_valid <= 1'b1;
        @(posedge clk);
        while (char_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input int count, input bit no_gaps);
        gapless = no_gaps;
        repeat (count) send_char(pick_char());
    endtask

    // Drop valid and wait until every pixel word has come back.
    task automatic drain();
        char_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        character  = '0;
        char_valid = 1'b0;
        gapless    = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        reg_access(1'b0, ADDR_TONE, '0);
        foreach (corner_chars[i]) send_char(corner_chars[i]);
        drain();

        reg_access(1'b1, ADDR_TONE, DATA_W'(12'hfff));
        // Spare index must leave the tone untouched.
        reg_access(1'b1, ADDR_SPARE, $urandom());
        reg_access(1'b0, ADDR_TONE, '0);
        send_random(60, 1'b0);
        drain();

        reg_access(1'b1, ADDR_TONE, '0);
        send_random(60, 1'b1);
        drain();

        // Upper bits are dropped on the way in.
        reg_access(1'b1, ADDR_TONE, {20'hfffff, 12'($urandom())});
        reg_access(1'b0, ADDR_TONE, '0);
        send_random(60, 1'b0);
        drain();

        reg_access(1'b1, ADDR_TONE, DATA_W'($urandom_range(1, 4094)));
        send_random(50, 1'b0);
        drain();

        if (outstanding != 0)
            $error("pixel words never arrived: %0d", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
